// ===== rtl/a85_pkg.sv =====
`timescale 1ns / 1ps

package a85_pkg;

   // One request: a byte slot plus the end marker.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_stream;
   } req_type;

   // One response: a single encoded character.
   typedef struct packed {
      logic [6:0] out_char;
      logic       last_char;
   } rsp_type;

   // Character source selected for the output register.
   localparam logic [1:0] SEL_DIGIT = 2'd0;
   localparam logic [1:0] SEL_Z     = 2'd1;
   localparam logic [1:0] SEL_TILDE = 2'd2;
   localparam logic [1:0] SEL_GT    = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      logic       load_flush;
      logic       mul;
      logic       div;
      logic       emit;
      logic [1:0] emit_sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_eos;
      logic full_hit;
      logic block_zero;
      logic grp_empty;
      logic div_last;
      logic emit_last;
      logic out_free;
   } sts_type;

   // Reciprocal of 85 for a 32-bit dividend: q = (v * RECIP_85) >> RECIP_SHIFT.
   localparam logic [31:0] RECIP_85    = 32'hC0C0_C0C1;
   localparam int          RECIP_SHIFT = 38;
   localparam logic [31:0] BASE        = 32'd85;

   // Character codes.
   localparam logic [6:0] CHAR_OFFSET = 7'd33;
   localparam logic [6:0] CHAR_Z      = 7'h7A;
   localparam logic [6:0] CHAR_TILDE  = 7'h7E;
   localparam logic [6:0] CHAR_GT     = 7'h3E;

   // Digit positions: five base-85 digits per group, index 4 is most significant.
   localparam logic [2:0] DIG_TOP = 3'd4;

endpackage

// ===== rtl/ascii85_stream_encoder.sv =====
`timescale 1ns / 1ps
//  Channel  Direction  Handshake              Payload
//  req_     in         req_valid/req_ready    req_type: data_byte, has_byte, end_of_stream
//  rsp_     out        rsp_valid/rsp_ready    rsp_type: out_char, last_char
//
//  A request that does not complete a group or end the stream leaves the block idle.
//  A completed group is converted in five multiply/remainder steps, one per base-85 digit,
//  and then emits one character per cycle while the output is free (all zeros: just z).
//  The end flush first converts a leftover group, if there is one, and emits its digits,
//  then emits "~>", one character per cycle while the output is free.
//  Synchronous active-high reset clears the group and returns to idle.
//  A stalled response holds in the output register; the sequencer waits on it.

module ascii85_stream_encoder import a85_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   a85_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   a85_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // The end-of-stream marker is only ever sent on the terminator's closing character.
   a_last_is_gt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_char) |-> (rsp_data.out_char == CHAR_GT))
      else $error("last_char set on a character other than the terminator");

   // The end of the stream always leaves the block busy: a completed group is converted first, then the flush.
   a_eos_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.end_of_stream) |=> !req_ready)
      else $error("request taken while the end of stream is being flushed");

   // A completed group starts its output work right away.
   a_group_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && sts.full_hit) |=> !req_ready)
      else $error("request taken while a completed group is pending");

endmodule

// ===== rtl/a85_dpath.sv =====
`timescale 1ns / 1ps

module a85_dpath import a85_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic [23:0] grp_bytes_ff, grp_bytes_in;
   logic [1:0]  grp_cnt_ff, grp_cnt_in;
   logic [31:0] conv_ff, conv_in;
   logic [63:0] prod_ff, prod_in;
   logic [6:0]  dig_ff [0:4];
   logic [6:0]  dig_in [0:4];
   logic [2:0]  div_idx_ff, div_idx_in;
   logic [2:0]  emit_idx_ff, emit_idx_in;
   logic [2:0]  stop_idx_ff, stop_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [31:0] full_block;
   logic [31:0] pad_block;
   logic [25:0] quo;
   logic [31:0] rem_wide;
   logic [6:0]  digit;
   logic        out_free;

   // The completed group and the zero-padded partial group.
   assign full_block = {grp_bytes_ff, req_data.data_byte};

   always_comb begin
      case (grp_cnt_ff)
         2'd1:    pad_block = {grp_bytes_ff[7:0], 24'd0};
         2'd2:    pad_block = {grp_bytes_ff[15:0], 16'd0};
         2'd3:    pad_block = {grp_bytes_ff, 8'd0};
         default: pad_block = 32'd0;
      endcase
   end

   // Quotient from the registered reciprocal product, then the remainder.
   assign quo      = prod_ff[RECIP_SHIFT +: 26];
   assign rem_wide = conv_ff - ({6'd0, quo} * BASE);
   assign digit    = rem_wide[6:0];

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Group accumulation, conversion and digit bookkeeping.
   always_comb begin
      grp_bytes_in = grp_bytes_ff;
      grp_cnt_in   = grp_cnt_ff;
      conv_in      = conv_ff;
      prod_in      = prod_ff;
      div_idx_in   = div_idx_ff;
      emit_idx_in  = emit_idx_ff;
      stop_idx_in  = stop_idx_ff;
      for (int k = 0; k < 5; k++) begin
         dig_in[k] = dig_ff[k];
      end

      if (cmd.accept && req_data.has_byte) begin
         if (grp_cnt_ff == 2'd3) begin
            conv_in      = full_block;
            grp_bytes_in = 24'd0;
            grp_cnt_in   = 2'd0;
            div_idx_in   = 3'd0;
            emit_idx_in  = DIG_TOP;
            stop_idx_in  = 3'd0;
         end else begin
            grp_bytes_in = {grp_bytes_ff[15:0], req_data.data_byte};
            grp_cnt_in   = grp_cnt_ff + 2'd1;
         end
      end

      if (cmd.load_flush) begin
         conv_in      = pad_block;
         grp_bytes_in = 24'd0;
         grp_cnt_in   = 2'd0;
         div_idx_in   = 3'd0;
         emit_idx_in  = DIG_TOP;
         stop_idx_in  = DIG_TOP - {1'b0, grp_cnt_ff};
      end

      if (cmd.mul) begin
         prod_in = {32'd0, conv_ff} * {32'd0, RECIP_85};
      end

      if (cmd.div) begin
         dig_in[div_idx_ff] = digit;
         conv_in            = {6'd0, quo};
         div_idx_in         = div_idx_ff + 3'd1;
      end

      if (cmd.emit && out_free && (cmd.emit_sel == SEL_DIGIT)) begin
         emit_idx_in = emit_idx_ff - 3'd1;
      end
   end

   // Output register: loads when empty or being drained.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit && out_free) begin
         rsp_valid_in = 1'b1;
         unique case (cmd.emit_sel)
            SEL_DIGIT: rsp_data_in = '{out_char: dig_ff[emit_idx_ff] + CHAR_OFFSET,
                                       last_char: 1'b0};
            SEL_Z:     rsp_data_in = '{out_char: CHAR_Z, last_char: 1'b0};
            SEL_TILDE: rsp_data_in = '{out_char: CHAR_TILDE, last_char: 1'b0};
            SEL_GT:    rsp_data_in = '{out_char: CHAR_GT, last_char: 1'b1};
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_bytes_ff <= 24'd0;
         grp_cnt_ff   <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         grp_bytes_ff <= grp_bytes_in;
         grp_cnt_ff   <= grp_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      conv_ff     <= conv_in;
      prod_ff     <= prod_in;
      div_idx_ff  <= div_idx_in;
      emit_idx_ff <= emit_idx_in;
      stop_idx_ff <= stop_idx_in;
      rsp_data_ff <= rsp_data_in;
      for (int k = 0; k < 5; k++) begin
         dig_ff[k] <= dig_in[k];
      end
   end

   // Status back to the controller.
   assign sts = '{req_eos:    req_data.end_of_stream,
                  full_hit:   req_data.has_byte && (grp_cnt_ff == 2'd3),
                  block_zero: (full_block == 32'd0),
                  grp_empty:  (grp_cnt_ff == 2'd0),
                  div_last:   (div_idx_ff == DIG_TOP),
                  emit_last:  (emit_idx_ff == stop_idx_ff),
                  out_free:   out_free};

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/a85_ctrl.sv =====
`timescale 1ns / 1ps

module a85_ctrl import a85_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FLUSH = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;
   localparam logic [2:0] S_ZCHAR = 3'd5;
   localparam logic [2:0] S_TILDE = 3'd6;
   localparam logic [2:0] S_GT    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       eos_ff, eos_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      eos_in   = eos_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = accept;
            if (accept) begin
               eos_in = sts.req_eos;
               if (sts.full_hit) begin
                  state_in = sts.block_zero ? S_ZCHAR : S_MUL;
               end else if (sts.req_eos) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            // A leftover partial group is converted; otherwise only the terminator.
            if (sts.grp_empty) begin
               state_in = S_TILDE;
            end else begin
               cmd.load_flush = 1'b1;
               state_in       = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div  = 1'b1;
            state_in = sts.div_last ? S_EMIT : S_MUL;
         end
         S_EMIT: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = SEL_DIGIT;
            if (sts.out_free && sts.emit_last) begin
               state_in = eos_ff ? S_FLUSH : S_IDLE;
            end
         end
         S_ZCHAR: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = SEL_Z;
            if (sts.out_free) begin
               state_in = eos_ff ? S_FLUSH : S_IDLE;
            end
         end
         S_TILDE: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = SEL_TILDE;
            if (sts.out_free) begin
               state_in = S_GT;
            end
         end
         S_GT: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = SEL_GT;
            if (sts.out_free) begin
               eos_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         eos_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         eos_ff   <= eos_in;
      end
   end

endmodule
